// ----- hw/rtl/scd_pkg.sv -----
package scd_pkg;

    localparam int NUM_WORDS = 5;
    localparam int LEN_W     = 4;

    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_GT  = 8'h3E;
    localparam logic [7:0] CHAR_LT  = 8'h3C;

    // Word slots: kill, killall, pkill, nohup, disown.
    localparam logic [2:0] W_KILL    = 3'd0;
    localparam logic [2:0] W_KILLALL = 3'd1;
    localparam logic [2:0] W_PKILL   = 3'd2;
    localparam logic [2:0] W_NOHUP   = 3'd3;
    localparam logic [2:0] W_DISOWN  = 3'd4;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_AMP  = 2'd1,
        CLS_GT   = 2'd2,
        CLS_LT   = 2'd3
    } t_cls;

    typedef enum logic [3:0] {
        LTR_OTHER,
        LTR_A, LTR_D, LTR_H, LTR_I, LTR_K, LTR_L,
        LTR_N, LTR_O, LTR_P, LTR_S, LTR_U, LTR_W
    } t_letter;

    typedef struct packed {
        logic    word;
        t_cls    cls;
        t_letter letter;
        logic    last;
    } t_token;

    typedef struct packed {
        logic kill_found;
        logic nohup_found;
        logic disown_found;
        logic background_found;
    } t_result;

    function automatic logic [LEN_W-1:0] word_len(input logic [2:0] w);
        logic [LEN_W-1:0] len;
        case (w)
            W_KILL:    len = 4'd4;
            W_KILLALL: len = 4'd7;
            W_PKILL:   len = 4'd5;
            W_NOHUP:   len = 4'd5;
            W_DISOWN:  len = 4'd6;
            default:   len = 4'd0;
        endcase
        return len;
    endfunction

    // Letter expected at a position of a word; only meaningful below its length.
    function automatic t_letter word_letter(input logic [2:0] w, input logic [2:0] pos);
        t_letter l;
        l = LTR_OTHER;
        case (w)
            W_KILL, W_KILLALL: begin
                case (pos)
                    3'd0:    l = LTR_K;
                    3'd1:    l = LTR_I;
                    3'd4:    l = LTR_A;
                    default: l = LTR_L;
                endcase
            end
            W_PKILL: begin
                case (pos)
                    3'd0:    l = LTR_P;
                    3'd1:    l = LTR_K;
                    3'd2:    l = LTR_I;
                    default: l = LTR_L;
                endcase
            end
            W_NOHUP: begin
                case (pos)
                    3'd0:    l = LTR_N;
                    3'd1:    l = LTR_O;
                    3'd2:    l = LTR_H;
                    3'd3:    l = LTR_U;
                    default: l = LTR_P;
                endcase
            end
            W_DISOWN: begin
                case (pos)
                    3'd0:    l = LTR_D;
                    3'd1:    l = LTR_I;
                    3'd2:    l = LTR_S;
                    3'd3:    l = LTR_O;
                    3'd4:    l = LTR_W;
                    default: l = LTR_N;
                endcase
            end
            default: l = LTR_OTHER;
        endcase
        return l;
    endfunction

endpackage

// ----- hw/rtl/scd_if.sv -----
interface scd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface scd_out_if;
    logic valid;
    logic ready;
    logic kill_found;
    logic nohup_found;
    logic disown_found;
    logic background_found;

    modport source (output valid, output kill_found, output nohup_found,
                    output disown_found, output background_found, input ready);
    modport sink (input valid, input kill_found, input nohup_found,
                  input disown_found, input background_found, output ready);
endinterface

// ----- hw/rtl/scd_front.sv -----
module scd_front
    import scd_pkg::*;
(
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output t_token     o_token
);

    logic    is_upper;
    logic    is_lower;
    logic    is_digit;
    t_letter letter;
    t_cls    cls;

    assign is_upper = (i_byte_value >= 8'h41) && (i_byte_value <= 8'h5A);
    assign is_lower = (i_byte_value >= 8'h61) && (i_byte_value <= 8'h7A);
    assign is_digit = (i_byte_value >= 8'h30) && (i_byte_value <= 8'h39);

    always_comb begin
        case (i_byte_value)
            8'h61:   letter = LTR_A;
            8'h64:   letter = LTR_D;
            8'h68:   letter = LTR_H;
            8'h69:   letter = LTR_I;
            8'h6B:   letter = LTR_K;
            8'h6C:   letter = LTR_L;
            8'h6E:   letter = LTR_N;
            8'h6F:   letter = LTR_O;
            8'h70:   letter = LTR_P;
            8'h73:   letter = LTR_S;
            8'h75:   letter = LTR_U;
            8'h77:   letter = LTR_W;
            default: letter = LTR_OTHER;
        endcase
    end

    always_comb begin
        case (i_byte_value)
            CHAR_AMP: cls = CLS_AMP;
            CHAR_GT:  cls = CLS_GT;
            CHAR_LT:  cls = CLS_LT;
            default:  cls = CLS_NONE;
        endcase
    end

    assign o_token.word   = is_upper | is_lower | is_digit | (i_byte_value == 8'h5F);
    assign o_token.cls    = cls;
    assign o_token.letter = letter;
    assign o_token.last   = i_last_byte;

endmodule

// ----- hw/rtl/scd_fifo.sv -----
module scd_fifo
    import scd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_token o_data
);

    t_token     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = r_count[1];
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/scd_back.sv -----
module scd_back
    import scd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tok_valid,
    input  t_token  i_tok,
    output logic    o_tok_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic [NUM_WORDS-1:0] r_cand;
    logic [LEN_W-1:0]     r_len;
    logic [2:0]           r_flags;
    logic                 r_amp;
    t_cls                 r_prev;
    logic                 r_bg;
    logic                 r_out_valid;
    t_result              r_out;

    logic [NUM_WORDS-1:0] n_cand;
    logic [LEN_W-1:0]     n_len;
    logic [2:0]           n_flags;
    logic                 n_amp;
    logic                 n_bg;
    logic [NUM_WORDS-1:0] hit_close;
    logic [NUM_WORDS-1:0] hit_last;
    logic [NUM_WORDS-1:0] ext_cand;
    logic [2:0]           fin_flags;
    logic                 pop;

    // A final byte may only move on when the result register is free or draining.
    assign pop       = i_tok_valid && (!i_tok.last || !r_out_valid || i_ready);
    assign o_tok_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            ext_cand[i]  = r_cand[i] && (r_len < word_len(3'(i))) &&
                           (word_letter(3'(i), r_len[2:0]) == i_tok.letter);
            hit_close[i] = r_cand[i] && (r_len != '0) && (r_len == word_len(3'(i)));
        end
    end

    always_comb begin
        if (i_tok.word) begin
            n_cand  = ext_cand;
            n_len   = (r_len == '1) ? r_len : r_len + LEN_W'(1);
            n_flags = r_flags;
        end else begin
            n_cand  = '1;
            n_len   = '0;
            n_flags = r_flags | {hit_close[W_DISOWN], hit_close[W_NOHUP],
                                 |hit_close[W_PKILL:W_KILL]};
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            hit_last[i] = n_cand[i] && (n_len != '0) && (n_len == word_len(3'(i)));
        end
        fin_flags = n_flags | {hit_last[W_DISOWN], hit_last[W_NOHUP],
                               |hit_last[W_PKILL:W_KILL]};
        n_bg  = r_bg | (r_amp && (i_tok.cls != CLS_AMP) && (i_tok.cls != CLS_GT));
        n_amp = (i_tok.cls == CLS_AMP) && (r_prev == CLS_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand      <= '1;
            r_len       <= '0;
            r_flags     <= '0;
            r_amp       <= 1'b0;
            r_prev      <= CLS_NONE;
            r_bg        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop && i_tok.last) begin
                r_cand      <= '1;
                r_len       <= '0;
                r_flags     <= '0;
                r_amp       <= 1'b0;
                r_prev      <= CLS_NONE;
                r_bg        <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (pop) begin
                    r_cand  <= n_cand;
                    r_len   <= n_len;
                    r_flags <= n_flags;
                    r_amp   <= n_amp;
                    r_prev  <= i_tok.cls;
                    r_bg    <= n_bg;
                end
                if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_tok.last) begin
            r_out.kill_found       <= fin_flags[0];
            r_out.nohup_found      <= fin_flags[1];
            r_out.disown_found     <= fin_flags[2];
            r_out.background_found <= n_bg | n_amp;
        end
    end

endmodule

// ----- hw/rtl/shell_process_control_detector.sv -----
// Shell process-control detector. Command bytes enter one per transfer on i_in, with
// last_byte set on the final byte; one transfer leaves on o_out per command, flagging
// the whole words kill/killall/pkill, nohup and disown and any backgrounding ampersand.
// The block takes one byte per clock cycle: a classifier feeds a two-entry queue, and
// the scanner behind it retires one queued byte per cycle into the word and ampersand
// state. A result sits in an output register, so bytes of the next command keep
// flowing while it waits; only a further final byte stalls until the result is taken.
// A final byte passes through the queue to the scanner, which registers its result onto o_out.
module shell_process_control_detector
    import scd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    scd_in_if.sink    i_in,
    scd_out_if.source o_out
);

    t_token  front_tok;
    t_token  q_tok;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    push;
    t_result result;

    assign i_in.ready = !q_full;
    assign push       = i_in.valid && !q_full;

    scd_front u_front (
        .i_byte_value (i_in.byte_value),
        .i_last_byte  (i_in.last_byte),
        .o_token      (front_tok)
    );

    scd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_tok)
    );

    scd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!q_empty),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .o_valid     (o_out.valid),
        .o_result    (result),
        .i_ready     (o_out.ready)
    );

    assign o_out.kill_found       = result.kill_found;
    assign o_out.nohup_found      = result.nohup_found;
    assign o_out.disown_found     = result.disown_found;
    assign o_out.background_found = result.background_found;

endmodule

// ----- test/scd_flag_checker.sv -----
module scd_flag_checker
    import scd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  logic       i_cmd_ready,
    input  logic [7:0] i_cmd_byte,
    input  logic       i_cmd_last,
    input  logic       i_flag_valid,
    input  logic       i_flag_ready,
    input  logic       i_kill,
    input  logic       i_nohup,
    input  logic       i_disown,
    input  logic       i_background,
    output int         o_failures,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [NUM_WORDS-1:0] candidates;
    logic [LEN_W-1:0]     run_len;
    logic [2:0]           words_seen;
    logic                 amp_waiting;
    t_cls                 prev_cls;
    logic                 background_seen;
    t_result              flags_due[$];
    int                   failures = 0;

    function automatic string word_text(input int w);
        string s;
        case (w)
            W_KILL:    s = "kill";
            W_KILLALL: s = "killall";
            W_PKILL:   s = "pkill";
            W_NOHUP:   s = "nohup";
            default:   s = "disown";
        endcase
        return s;
    endfunction

    // The three kill spellings share one result flag.
    function automatic int word_group(input int w);
        int g;
        if (w == W_NOHUP)
            g = 1;
        else if (w == W_DISOWN)
            g = 2;
        else
            g = 0;
        return g;
    endfunction

    function automatic logic is_word_char(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               (b >= "0" && b <= "9") || b == "_";
    endfunction

    task automatic clear_scan();
        candidates      = '1;
        run_len         = '0;
        words_seen      = '0;
        amp_waiting     = 1'b0;
        prev_cls        = CLS_NONE;
        background_seen = 1'b0;
    endtask

    task automatic end_run();
        string s;
        if (run_len != 0) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                s = word_text(w);
                if (candidates[w] && s.len() == run_len)
                    words_seen[word_group(w)] = 1'b1;
            end
        end
        candidates = '1;
        run_len    = '0;
    endtask

    task automatic extend_run(input logic [7:0] b);
        string s;
        for (int w = 0; w < NUM_WORDS; w++) begin
            s = word_text(w);
            if (candidates[w]) begin
                if (run_len >= s.len())
                    candidates[w] = 1'b0;
                else if (s[run_len] != b)
                    candidates[w] = 1'b0;
            end
        end
        if (run_len != 4'd15)
            run_len = run_len + 4'd1;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic fin);
        t_result r;
        if (is_word_char(b))
            extend_run(b);
        else
            end_run();
        if (amp_waiting && b != CHAR_AMP && b != CHAR_GT)
            background_seen = 1'b1;
        amp_waiting = (b == CHAR_AMP) && (prev_cls == CLS_NONE);
        if (b == CHAR_AMP)
            prev_cls = CLS_AMP;
        else if (b == CHAR_GT)
            prev_cls = CLS_GT;
        else if (b == CHAR_LT)
            prev_cls = CLS_LT;
        else
            prev_cls = CLS_NONE;
        if (fin) begin
            end_run();
            // A trailing ampersand has no successor to disqualify it.
            if (amp_waiting)
                background_seen = 1'b1;
            r = '{kill_found: words_seen[0], nohup_found: words_seen[1],
                  disown_found: words_seen[2], background_found: background_seen};
            flags_due.insert(flags_due.size(), r);
            clear_scan();
        end
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            failures++;
            if (failures <= 10)
                $display("%0t: %s mismatch: expected %b, got %b", $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_scan();
            flags_due.delete();
        end else begin
            if (i_flag_valid && i_flag_ready) begin
                if (flags_due.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result transfer with no command pending: %b%b%b%b",
                                 $realtime, i_kill, i_nohup, i_disown, i_background);
                end else begin
                    want = flags_due.pop_front();
                    check_field("kill_found", want.kill_found, i_kill);
                    check_field("nohup_found", want.nohup_found, i_nohup);
                    check_field("disown_found", want.disown_found, i_disown);
                    check_field("background_found", want.background_found, i_background);
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                scan_byte(i_cmd_byte, i_cmd_last);
        end
        o_pending  <= flags_due.size();
        o_failures <= failures;
    end

endmodule

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import scd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_BYTES = 1600;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   pending;
    int   sent_bytes = 0;
    int   burst_left = 8;
    int   cycle_count = 0;
    logic [7:0] cmd_buf[$];

    scd_in_if  cmd_ch();
    scd_out_if flag_ch();

    shell_process_control_detector dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (cmd_ch),
        .o_out  (flag_ch)
    );

    scd_flag_checker flag_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_ch.valid),
        .i_cmd_ready (cmd_ch.ready),
        .i_cmd_byte  (cmd_ch.byte_value),
        .i_cmd_last  (cmd_ch.last_byte),
        .i_flag_valid(flag_ch.valid),
        .i_flag_ready(flag_ch.ready),
        .i_kill      (flag_ch.kill_found),
        .i_nohup     (flag_ch.nohup_found),
        .i_disown    (flag_ch.disown_found),
        .i_background(flag_ch.background_found),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL shell_process_control_detector");
            $finish;
        end
    end

    // Result side: stretches of steady, sparse and dense readiness, with a long
    // hold-off every sixth stretch so the block backs up into its input.
    initial begin
        int stretch_no;
        int mode;
        stretch_no = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stretch_no++;
            if (stretch_no % 6 == 3) begin
                flag_ch.ready <= 1'b0;
                repeat ($urandom_range(150, 300)) @(posedge clk);
            end else begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(10, 80)) begin
                    if (mode == 0)
                        flag_ch.ready <= 1'b1;
                    else if (mode == 1)
                        flag_ch.ready <= ($urandom_range(0, 3) != 0);
                    else
                        flag_ch.ready <= ($urandom_range(0, 3) == 0);
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.byte_value <= b;
        cmd_ch.last_byte  <= fin;
        do @(posedge clk); while (!cmd_ch.ready);
        sent_bytes++;
        burst_left--;
        if (burst_left <= 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(60, 200);
            else
                burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic send_command();
        for (int i = 0; i < cmd_buf.size(); i++)
            send_byte(cmd_buf[i], i == cmd_buf.size() - 1);
        cmd_buf.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        cmd_buf.insert(cmd_buf.size(), b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // Stop offering and hold until every command has produced its result.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] word_char();
        string near;
        logic [7:0] c;
        near = "kilpnohudswaKN";
        case ($urandom_range(0, 4))
            0: c = 8'($urandom_range("A", "Z"));
            1: c = 8'($urandom_range("a", "z"));
            2: c = 8'($urandom_range("0", "9"));
            3: c = "_";
            default: c = near[$urandom_range(0, near.len() - 1)];
        endcase
        return c;
    endfunction

    task automatic push_word();
        case ($urandom_range(0, 15))
            0:  push_text("kill");
            1:  push_text("killall");
            2:  push_text("pkill");
            3:  push_text("nohup");
            4:  push_text("disown");
            5:  push_text("kil");
            6:  push_text("killal");
            7:  push_text("killalll");
            8:  push_text("pkil");
            9:  push_text("xkill");
            10: push_text("Nohup");
            11: push_text("disowned");
            12: push_text("nohu");
            default: begin
                repeat ($urandom_range(1, 18))
                    add_byte(word_char());
            end
        endcase
    endtask

    task automatic push_separator();
        case ($urandom_range(0, 11))
            0, 1: push_text(" ");
            2:    push_text("&");
            3:    push_text("&&");
            4:    push_text(">&");
            5:    push_text("<&");
            6:    push_text("&>");
            7:    push_text("&<");
            8:    push_text(" | ");
            9:    push_text("; ");
            10:   push_text(" 2>&1 ");
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic push_noise();
        string pick;
        pick = "&&<> k";
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1) == 0)
                add_byte(8'($urandom_range(0, 255)));
            else
                add_byte(pick[$urandom_range(0, pick.len() - 1)]);
        end
    endtask

    initial begin
        int commands;
        cmd_ch.valid      = 1'b0;
        cmd_ch.byte_value = '0;
        cmd_ch.last_byte  = 1'b0;
        flag_ch.ready     = 1'b0;
        rst_n             = 1'b0;
        commands          = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Lone ampersand: no predecessor and no successor.
        push_text("&");
        send_command();
        push_text("kill&");
        send_command();
        // Ampersand after a redirect is not a background.
        push_text("nohup>&");
        send_command();
        push_text("disown");
        add_byte(8'hFF);
        send_command();
        push_text("killall");
        add_byte(8'h00);
        push_text("pkill");
        send_command();
        drain_results();

        while (sent_bytes < TARGET_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                push_noise();
            end else begin
                if ($urandom_range(0, 3) == 0)
                    push_separator();
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 2) == 0)
                        push_separator();
                    else
                        push_word();
                    if ($urandom_range(0, 2) != 0)
                        push_separator();
                end
            end
            send_command();
            commands++;
            if (commands % 40 == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASS shell_process_control_detector");
        else
            $display("FAIL shell_process_control_detector");
        $finish;
    end

endmodule
